[rtl/urf_pkg.sv]
package urf_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ECHO_DIV,
		ST_BLEND_PREV,
		ST_BLEND_SCL,
		ST_BLEND_SUM,
		ST_BLEND_MAG,
		ST_BLEND_DIV,
		ST_KEEP,
		ST_AVG_UPD,
		ST_AVG_DIV,
		ST_DONE
	} state_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SENSOR_KIND   = 3'd0,
		REG_FILTER_MODE   = 3'd1,
		REG_BLEND_WEIGHT  = 3'd2,
		REG_ANALOG_GAIN   = 3'd3,
		REG_DETECT_RANGE  = 3'd4,
		REG_SENSOR_ENABLE = 3'd5
	} cfg_reg_t;

	localparam logic       SENSOR_ECHO   = 1'b0;
	localparam logic       SENSOR_ANALOG = 1'b1;
	localparam logic [1:0] FILT_NONE     = 2'd0;
	localparam logic [1:0] FILT_AVG      = 2'd1;
	localparam logic [1:0] FILT_BLEND    = 2'd2;

	// echo: milli-cm = us * 17, accepted up to 400 cm
	localparam logic [4:0]  ECHO_FACTOR    = 5'd17;
	localparam logic [18:0] ECHO_MAX_MILLI = 19'd400000;
	localparam logic [9:0]  MILLI_PER_CM   = 10'd1000;

	// floor(n / 1000) = (n * ECHO_RECIP) >> ECHO_SHIFT for n below 2^19
	localparam logic [19:0] ECHO_RECIP  = 20'd536871;
	localparam int          ECHO_SHIFT  = 29;
	// floor(n / 1000) = (n * BLEND_RECIP) >> BLEND_SHIFT for n below 2^23
	localparam logic [23:0] BLEND_RECIP = 24'd8589935;
	localparam int          BLEND_SHIFT = 33;

	localparam logic [8:0]  W_FULL      = 9'd256;
	localparam logic [19:0] Q8_MAX      = 20'hFFFFF;
	localparam int          DETECT_HOLD = 5;

endpackage

[rtl/ultrasonic_range_filter.sv]
// ultrasonic range filter: one raw sonar reading in, one filtered distance out
// input channel (in_valid/in_ready) carries raw_reading: an echo width in us
// or an adc sample, depending on sensor_kind
// output channel (out_valid/out_ready) carries filtered_cm, distance_valid and
// object_detected, one word per input word, in order
// config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while the block is idle
// every product goes through one shared registered multiplier stepped by a
// small sequencer, so one word takes 2 to 9 cycles from accept until in_ready
// returns: disabled 2, analog unfiltered 3, echo unfiltered 4, moving average 5,
// analog blend 7, echo blend 9 (the blend chains four multiplies)
// in_ready is high only while the sequencer is idle
// the result lands in an output register; while the receiver stalls the next
// word can still be accepted and worked on, and the sequencer holds its
// finished result until the output register frees up
// reset clears the config registers to their defaults, the filter history,
// the sample counter and the window valid bits; no clearing pass is needed
module ultrasonic_range_filter #(
	parameter int WINDOW_TAPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input word
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] raw_reading,
	// result word
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] filtered_cm,
	output logic        distance_valid,
	output logic        object_detected,
	// config writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	// window geometry and the reciprocal for the average divide
	localparam int WIN_AW = $clog2(WINDOW_TAPS);
	localparam int SUM_W  = 12 + WIN_AW;
	localparam int AVG_K  = SUM_W + 7;
	localparam int AVG_M  = ((1 << AVG_K) + WINDOW_TAPS - 1) / WINDOW_TAPS;
	localparam int MUL_W  = (AVG_K + 1 > 26) ? AVG_K + 1 : 26;
	localparam int PW     = 2 * MUL_W;

	// config registers
	logic        sensor_kind_q;
	logic [1:0]  filter_mode_q;
	logic [8:0]  blend_weight_q;
	logic [9:0]  analog_gain_q;
	logic [11:0] detect_range_q;
	logic        sensor_enable_q;

	// filter state
	logic signed [12:0]       prev_q;
	logic [11:0]              stored_q;
	logic [SUM_W-1:0]         sum_q;
	logic [7:0]               count_q;
	logic [WIN_AW-1:0]        ptr_q;
	logic [WINDOW_TAPS-1:0]   wvalid_q;

	// sequencer
	urf_pkg::state_t state_q, state_d;
	logic            res_valid_q;
	logic            off_q;

	// per-word working registers
	logic [15:0]        raw_q;
	logic [19:0]        fresh_q;
	logic signed [31:0] acc_q;
	logic [31:0]        mag_q;
	logic               neg_q;
	logic [15:0]        quo_q;

	// output register
	logic        out_valid_q;
	logic [11:0] dist_q;
	logic        dvalid_q;
	logic        det_q;

	// shared multiplier
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PW-1:0]    prod;

	// window memory
	logic              ram_we, ram_re;
	logic [11:0]       ram_rdata;

	// combinational helpers
	logic              averaging;
	logic [8:0]        w_eff;
	logic [8:0]        w_rest;
	logic [19:0]       q8;
	logic              echo_ok;
	logic [11:0]       old_entry;
	logic [SUM_W-1:0]  sum_new;
	logic signed [31:0] num_c;
	logic              out_load;
	logic              det_c;

	urf_mul #(.W(MUL_W)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	urf_ram #(.WIDTH(12), .DEPTH(WINDOW_TAPS)) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (fresh_q[19:8]),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == urf_pkg::ST_IDLE);

	assign averaging = (sensor_kind_q == urf_pkg::SENSOR_ANALOG) &&
		(filter_mode_q == urf_pkg::FILT_AVG);
	// weights above full scale act as full scale
	assign w_eff  = (blend_weight_q > urf_pkg::W_FULL) ? urf_pkg::W_FULL : blend_weight_q;
	assign w_rest = urf_pkg::W_FULL - w_eff;

	// scaled reading straight off the product register (valid in ST_SCALE)
	assign q8      = (|prod[PW-1:20]) ? urf_pkg::Q8_MAX : prod[19:0];
	assign echo_ok = (raw_q != 16'd0) && !(|prod[PW-1:19]) &&
		(prod[18:0] <= urf_pkg::ECHO_MAX_MILLI);

	// running window sum: drop the oldest entry, add the new one
	assign old_entry = wvalid_q[ptr_q] ? ram_rdata : 12'd0;
	assign sum_new   = sum_q - SUM_W'(old_entry) + SUM_W'(fresh_q[19:8]);

	// blend numerator: new*w + prev*scale*(256-w)
	always_comb begin
		if (state_q == urf_pkg::ST_BLEND_SUM) begin
			num_c = acc_q + signed'(prod[31:0]);
		end else begin
			num_c = acc_q + (32'(signed'(prod[21:0])) <<< 8);
		end
	end

	assign det_c = !off_q &&
		!(averaging && (count_q < 8'(WINDOW_TAPS + urf_pkg::DETECT_HOLD))) &&
		(stored_q != 12'd0) && (stored_q < detect_range_q);

	// next state, multiplier operands, memory strobes
	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			urf_pkg::ST_IDLE: begin
				mul_a = MUL_W'(raw_reading);
				mul_b = (sensor_kind_q == urf_pkg::SENSOR_ANALOG) ?
					MUL_W'(analog_gain_q) : MUL_W'(urf_pkg::ECHO_FACTOR);
				if (in_valid) begin
					state_d = sensor_enable_q ? urf_pkg::ST_SCALE : urf_pkg::ST_DONE;
				end
			end
			urf_pkg::ST_SCALE: begin
				if (sensor_kind_q == urf_pkg::SENSOR_ECHO) begin
					mul_a = MUL_W'(prod[18:0]);
					if (!echo_ok) begin
						state_d = urf_pkg::ST_DONE;
					end else if (filter_mode_q == urf_pkg::FILT_BLEND) begin
						mul_b   = MUL_W'(w_eff);
						state_d = urf_pkg::ST_BLEND_PREV;
					end else begin
						mul_b   = MUL_W'(urf_pkg::ECHO_RECIP);
						state_d = urf_pkg::ST_ECHO_DIV;
					end
				end else begin
					mul_a = MUL_W'(q8);
					mul_b = MUL_W'(w_eff);
					case (filter_mode_q)
						urf_pkg::FILT_AVG: begin
							ram_re  = 1'b1;
							state_d = urf_pkg::ST_AVG_UPD;
						end
						urf_pkg::FILT_BLEND: state_d = urf_pkg::ST_BLEND_PREV;
						default:             state_d = urf_pkg::ST_DONE;
					endcase
				end
			end
			urf_pkg::ST_ECHO_DIV: state_d = urf_pkg::ST_DONE;
			urf_pkg::ST_BLEND_PREV: begin
				mul_a   = MUL_W'(prev_q);
				mul_b   = MUL_W'(w_rest);
				state_d = urf_pkg::ST_BLEND_SCL;
			end
			urf_pkg::ST_BLEND_SCL: begin
				if (sensor_kind_q == urf_pkg::SENSOR_ECHO) begin
					mul_a   = MUL_W'(signed'(prod[21:0]));
					mul_b   = MUL_W'(urf_pkg::MILLI_PER_CM);
					state_d = urf_pkg::ST_BLEND_SUM;
				end else begin
					state_d = urf_pkg::ST_BLEND_MAG;
				end
			end
			urf_pkg::ST_BLEND_SUM: state_d = urf_pkg::ST_BLEND_MAG;
			urf_pkg::ST_BLEND_MAG: begin
				if (sensor_kind_q == urf_pkg::SENSOR_ECHO) begin
					mul_a   = MUL_W'(mag_q[31:8]);
					mul_b   = MUL_W'(urf_pkg::BLEND_RECIP);
					state_d = urf_pkg::ST_BLEND_DIV;
				end else begin
					state_d = urf_pkg::ST_KEEP;
				end
			end
			urf_pkg::ST_BLEND_DIV: state_d = urf_pkg::ST_KEEP;
			urf_pkg::ST_KEEP:      state_d = urf_pkg::ST_DONE;
			urf_pkg::ST_AVG_UPD: begin
				ram_we  = 1'b1;
				mul_a   = MUL_W'(sum_new);
				mul_b   = MUL_W'(AVG_M);
				state_d = urf_pkg::ST_AVG_DIV;
			end
			urf_pkg::ST_AVG_DIV: state_d = urf_pkg::ST_DONE;
			urf_pkg::ST_DONE: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = urf_pkg::ST_IDLE;
				end
			end
			default: state_d = urf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= urf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_kind_q   <= urf_pkg::SENSOR_ECHO;
			filter_mode_q   <= urf_pkg::FILT_NONE;
			blend_weight_q  <= 9'd218;
			analog_gain_q   <= 10'd256;
			detect_range_q  <= 12'd40;
			sensor_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (urf_pkg::cfg_reg_t'(cfg_index))
				urf_pkg::REG_SENSOR_KIND:   sensor_kind_q   <= cfg_data[0];
				urf_pkg::REG_FILTER_MODE:   filter_mode_q   <= cfg_data[1:0];
				urf_pkg::REG_BLEND_WEIGHT:  blend_weight_q  <= cfg_data[8:0];
				urf_pkg::REG_ANALOG_GAIN:   analog_gain_q   <= cfg_data[9:0];
				urf_pkg::REG_DETECT_RANGE:  detect_range_q  <= cfg_data;
				urf_pkg::REG_SENSOR_ENABLE: sensor_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// filter state and sequencer flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			stored_q    <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			wvalid_q    <= '0;
			res_valid_q <= 1'b0;
			off_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word replaces the one being taken in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				urf_pkg::ST_IDLE: begin
					if (in_valid) begin
						res_valid_q <= 1'b0;
						off_q       <= !sensor_enable_q;
						if (!sensor_enable_q) begin
							prev_q <= -13'sd1;
						end
					end
				end
				urf_pkg::ST_SCALE: begin
					if (sensor_kind_q == urf_pkg::SENSOR_ANALOG || echo_ok) begin
						if (count_q != 8'hFF) begin
							count_q <= count_q + 8'd1;
						end
					end
					// analog with no filter keeps prev untouched
					if (sensor_kind_q == urf_pkg::SENSOR_ANALOG &&
						filter_mode_q != urf_pkg::FILT_AVG &&
						filter_mode_q != urf_pkg::FILT_BLEND) begin
						stored_q    <= q8[19:8];
						res_valid_q <= 1'b1;
					end
				end
				urf_pkg::ST_ECHO_DIV: begin
					stored_q    <= 12'(prod[urf_pkg::ECHO_SHIFT +: 9]);
					prev_q      <= signed'(13'(prod[urf_pkg::ECHO_SHIFT +: 9]));
					res_valid_q <= 1'b1;
				end
				urf_pkg::ST_KEEP: begin
					// truncate toward zero, then clamp each copy to its range
					if (neg_q) begin
						stored_q <= 12'd0;
						prev_q   <= (quo_q >= 16'd4096) ? -13'sd4096 :
							-signed'(13'(quo_q));
					end else begin
						stored_q <= (quo_q > 16'd4095) ? 12'hFFF : quo_q[11:0];
						prev_q   <= (quo_q > 16'd4095) ? 13'sd4095 : signed'(13'(quo_q));
					end
					res_valid_q <= 1'b1;
				end
				urf_pkg::ST_AVG_UPD: begin
					sum_q           <= sum_new;
					wvalid_q[ptr_q] <= 1'b1;
					ptr_q <= (ptr_q == WIN_AW'(WINDOW_TAPS - 1)) ? '0 : ptr_q + 1'b1;
				end
				urf_pkg::ST_AVG_DIV: begin
					stored_q    <= prod[AVG_K +: 12];
					res_valid_q <= (count_q > 8'(WINDOW_TAPS));
				end
				default: ;
			endcase
		end
	end

	// per-word working registers and output payload
	always_ff @(posedge clk) begin
		if (state_q == urf_pkg::ST_IDLE && in_valid) begin
			raw_q <= raw_reading;
		end
		if (state_q == urf_pkg::ST_SCALE) begin
			fresh_q <= (sensor_kind_q == urf_pkg::SENSOR_ECHO) ? {1'b0, prod[18:0]} : q8;
		end
		if (state_q == urf_pkg::ST_BLEND_PREV) begin
			acc_q <= signed'(prod[31:0]);
		end
		if ((state_q == urf_pkg::ST_BLEND_SUM) ||
			(state_q == urf_pkg::ST_BLEND_SCL && sensor_kind_q == urf_pkg::SENSOR_ANALOG)) begin
			neg_q <= num_c[31];
			mag_q <= num_c[31] ? 32'(-num_c) : 32'(num_c);
		end
		if (state_q == urf_pkg::ST_BLEND_MAG) begin
			quo_q <= mag_q[31:16];
		end
		if (state_q == urf_pkg::ST_BLEND_DIV) begin
			quo_q <= prod[urf_pkg::BLEND_SHIFT +: 16];
		end
		if (out_load) begin
			dist_q   <= res_valid_q ? stored_q : 12'd0;
			dvalid_q <= res_valid_q;
			det_q    <= det_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_cm     = dist_q;
	assign distance_valid  = dvalid_q;
	assign object_detected = det_q;

	// running sum never exceeds a full window of maximum entries
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(WINDOW_TAPS * 4095))
		else $error("window sum out of range");

	// window fills in order, so the entry behind the pointer is always valid
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q != '0) |-> wvalid_q[ptr_q - 1'b1])
		else $error("window valid bits out of order");

	// a disabled word finishes with the history marked as minus one
	a_off_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == urf_pkg::ST_DONE && off_q) |-> (prev_q == -13'sd1 && !res_valid_q))
		else $error("disabled word left history or valid flag wrong");

	// an invalid word carries no distance
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !dvalid_q) |-> (dist_q == 12'd0))
		else $error("invalid word with nonzero distance");

	// accepting a word always starts the sequencer
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != urf_pkg::ST_IDLE))
		else $error("accepted word did not start");

endmodule

[rtl/urf_ram.sv]
module urf_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/urf_mul.sv]
module urf_mul #(
	parameter int W = 26
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	// registered signed product, loaded every cycle
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule
